// ===== hdl/sorted_table_binary_search_assert.svh =====
`ifndef SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH

// Checks that a condition holds at every clock edge outside reset.
`define BSRCH_ASSERT_HOLD(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a trigger is followed by a condition at the next clock edge.
`define BSRCH_ASSERT_NEXT(lbl, trig, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) else $error(msg);

// Checks that a signal keeps its value at the edge after a trigger.
`define BSRCH_ASSERT_STABLE(lbl, trig, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> $stable(sig)) \
        else $error(msg);

`endif

// ===== hdl/bsrch_pkg.sv =====
package bsrch_pkg;

    localparam int CMD_W  = 1;
    localparam int IDX_W  = 10;
    localparam int DATA_W = 32;
    localparam int CNT_W  = 11;
    localparam int POS_W  = 11;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

endpackage

// ===== hdl/bsrch_table.sv =====
module bsrch_table
    import bsrch_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int AW = 10
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [TABLE_DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/bsrch_ctrl.sv =====
module bsrch_ctrl
    import bsrch_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int AW = 10,
    parameter int CW = 11
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [CNT_W-1:0]  cfg_wr_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CMD_W-1:0]  cmd,
    input  logic [IDX_W-1:0]  entry_index,
    input  logic [DATA_W-1:0] value,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [POS_W-1:0]  position,
    output logic              tbl_we,
    output logic [AW-1:0]     tbl_waddr,
    output logic [DATA_W-1:0] tbl_wdata,
    output logic [AW-1:0]     tbl_raddr,
    input  logic [DATA_W-1:0] tbl_rdata
);

    localparam int SW = (CW > CNT_W) ? CW : CNT_W;
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PROBE = 2'd1;
    localparam logic [1:0] S_CMP   = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [CW-1:0]      lo_reg, lo_next;
    logic [CW-1:0]      hi_reg, hi_next;
    logic [CW-1:0]      mid_reg, mid_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               out_valid_reg, out_valid_next;
    logic [POS_W-1:0]   position_reg, position_next;

    logic               accept_in;
    logic               out_free;
    logic [CW-1:0]      hi_init;
    logic               idx_ok;
    logic [CW-1:0]      mid_calc;
    logic               entry_gt;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept_in = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign hi_init  = (SW'(count_reg) > SW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(count_reg);
    assign idx_ok   = XW'(entry_index) < XW'(TABLE_DEPTH);
    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign entry_gt = $signed(tbl_rdata) > key_reg;

    assign tbl_we    = accept_in && (cmd == CMD_LOAD) && idx_ok;
    assign tbl_waddr = AW'(entry_index);
    assign tbl_wdata = value;
    assign tbl_raddr = AW'(mid_calc);

    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        key_next       = key_reg;
        count_next     = cfg_wr_en ? cfg_wr_data : count_reg;
        out_valid_next = out_valid_reg && out_stall;
        position_next  = position_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept_in && (cmd == CMD_QUERY))
                begin
                    lo_next    = '0;
                    hi_next    = hi_init;
                    key_next   = $signed(value);
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_calc;
                    state_next = S_CMP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_CMP:
            begin
                if (entry_gt)
                begin
                    hi_next = mid_reg;
                end
                else
                begin
                    lo_next = mid_reg + CW'(1);
                end
                state_next = S_PROBE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    position_next  = POS_W'(lo_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        key_reg      <= key_next;
        position_reg <= position_next;
    end

    assign out_valid = out_valid_reg;
    assign position  = position_reg;

endmodule

// ===== hdl/sorted_table_binary_search.sv =====
// Upper-bound search over a sorted table of signed 32-bit entries held in one
// synchronous RAM of TABLE_DEPTH words. A load item (cmd 0) writes one entry
// and gives no result; loads at an index at or beyond TABLE_DEPTH are
// dropped. A query item (cmd 1) returns position, the number of the first
// entries_in_use entries (saturated to TABLE_DEPTH) that are less than or
// equal to the value. Each probe is one RAM read and one signed compare. A
// query holds in_stall high from when it is taken until its result enters the
// output register, which waits while the previous result is still held there.
// Items are taken one at a time, but a new item is accepted while the previous
// result still waits in the output register. The table is not cleared by
// reset, and every searched entry must be loaded before it is queried.
module sorted_table_binary_search
    import bsrch_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [CNT_W-1:0]  cfg_wr_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CMD_W-1:0]  cmd,
    input  logic [IDX_W-1:0]  entry_index,
    input  logic [DATA_W-1:0] value,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [POS_W-1:0]  position
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic              tbl_we;
    logic [AW-1:0]     tbl_waddr;
    logic [DATA_W-1:0] tbl_wdata;
    logic [AW-1:0]     tbl_raddr;
    logic [DATA_W-1:0] tbl_rdata;

    bsrch_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .entry_index (entry_index),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .position    (position),
        .tbl_we      (tbl_we),
        .tbl_waddr   (tbl_waddr),
        .tbl_wdata   (tbl_wdata),
        .tbl_raddr   (tbl_raddr),
        .tbl_rdata   (tbl_rdata)
    );

    bsrch_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

endmodule

// ===== hdl/bsrch_checker.sv =====
`include "sorted_table_binary_search_assert.svh"

module bsrch_checker
    import bsrch_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic [CMD_W-1:0]  cmd,
    input logic              out_valid,
    input logic              out_stall,
    input logic [POS_W-1:0]  position
);

    logic in_accept;

    assign in_accept = in_valid && !in_stall;

    `BSRCH_ASSERT_NEXT(a_out_valid_held, out_valid && out_stall, out_valid, "stalled result item dropped")
    `BSRCH_ASSERT_STABLE(a_out_data_held, out_valid && out_stall, position, "stalled result item changed")
    `BSRCH_ASSERT_HOLD(a_position_range, !out_valid || (position <= TABLE_DEPTH), "position beyond table depth")
    `BSRCH_ASSERT_NEXT(a_query_busy, in_accept && (cmd == CMD_QUERY), in_stall, "query item did not occupy the block")
    `BSRCH_ASSERT_NEXT(a_load_silent, in_accept && (cmd == CMD_LOAD) && !out_valid, !out_valid, "load item produced a result")

endmodule

bind sorted_table_binary_search bsrch_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_bsrch_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .position  (position)
);

// ===== bench/sorted_table_binary_search_tb.sv =====
`timescale 1ns / 1ps

module sorted_table_binary_search_tb;
    import bsrch_pkg::*;

    localparam int TABLE_DEPTH = 1024;
    localparam int ITEM_GOAL = 1600;
    localparam int DRAIN_CYCLES = 40;
    localparam int DIRECTED_ROWS = 25;

    typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [CMD_W-1:0]   cmd;
        logic [IDX_W-1:0]   slot;
        logic [DATA_W-1:0]  data;
        bit                 typed;
        logic [POS_W-1:0]   want;
    } directed_row_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [CNT_W-1:0]  cfg_wr_data;
    logic              in_valid;
    logic              in_stall;
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  entry_index;
    logic [DATA_W-1:0] value;
    logic              out_valid;
    logic              out_stall;
    logic [POS_W-1:0]  position;

    logic [DATA_W-1:0] mirror_entries [TABLE_DEPTH];
    bit                entry_loaded [TABLE_DEPTH];
    int                loaded_prefix;
    logic [CNT_W-1:0]  mirror_count;
    logic [POS_W-1:0]  pending_positions [$];
    directed_row_t     plan [DIRECTED_ROWS];
    int                error_count;
    int                item_count;
    int                burst_left;

    sorted_table_binary_search u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .entry_index (entry_index),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .position    (position)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("[sorted_table_binary_search] ERROR");
        $finish;
    end

    function automatic int search_limit();
        return (mirror_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(mirror_count);
    endfunction

    function automatic logic [POS_W-1:0] predict_position(input logic [DATA_W-1:0] key);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = search_limit();
        while (lo < hi)
        begin
            mid = lo + ((hi - lo) >> 1);
            if ($signed(mirror_entries[mid]) > $signed(key))
                hi = mid;
            else
                lo = mid + 1;
        end
        return lo[POS_W-1:0];
    endfunction

    task automatic send_item(input logic [CMD_W-1:0] item_cmd,
                             input logic [IDX_W-1:0] item_index,
                             input logic [DATA_W-1:0] item_value,
                             input bit typed,
                             input logic [POS_W-1:0] typed_position);
        int gap;
        bit taken;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid    <= 1'b1;
        cmd         <= item_cmd;
        entry_index <= item_index;
        value       <= item_value;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        item_count++;
        if (item_cmd == CMD_LOAD)
        begin
            mirror_entries[item_index] = item_value;
            entry_loaded[item_index] = 1'b1;
            while (loaded_prefix < TABLE_DEPTH && entry_loaded[loaded_prefix])
                loaded_prefix++;
        end
        else
        begin
            pending_positions = {pending_positions,
                                 (typed ? typed_position : predict_position(item_value))};
        end
    endtask

    task automatic configure_count(input logic [CNT_W-1:0] count);
        in_valid <= 1'b0;
        while (pending_positions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= count;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        mirror_count = count;
    endtask

    task automatic random_query();
        int lim;
        logic [DATA_W-1:0] key;
        lim = search_limit();
        case ($urandom_range(0, 5))
            0, 1: key = (lim > 0) ? mirror_entries[$urandom_range(0, lim - 1)] : $urandom;
            2: key = (lim > 0) ? mirror_entries[$urandom_range(0, lim - 1)]
                                 + ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF)
                               : $urandom;
            3: key = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: key = $urandom;
        endcase
        send_item(CMD_QUERY, IDX_W'($urandom_range(0, TABLE_DEPTH - 1)), key, 1'b0, '0);
    endtask

    task automatic query_run(input int count);
        int lim;
        int slot;
        for (int i = 0; i < count; i++)
        begin
            lim = search_limit();
            if ($urandom_range(0, 99) < 12)
            begin
                slot = (lim < TABLE_DEPTH && $urandom_range(0, 1))
                       ? $urandom_range(lim, TABLE_DEPTH - 1)
                       : $urandom_range(0, TABLE_DEPTH - 1);
                send_item(CMD_LOAD, IDX_W'(slot), $urandom, 1'b0, '0);
            end
            else if (lim <= loaded_prefix)
            begin
                random_query();
            end
        end
    endtask

    task automatic fill_entries(input int n, input bit wide, input bit keep_sorted,
                                input bit shuffled, input int query_pct);
        int vals[$];
        int order[$];
        int base;
        base = $urandom;
        for (int i = 0; i < n; i++)
        begin
            vals = {vals, (wide ? int'($urandom) : base + int'($urandom_range(0, 15)))};
            order = {order, i};
        end
        if (keep_sorted)
            vals.sort();
        if (shuffled)
            order.shuffle();
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 99) < query_pct && search_limit() <= loaded_prefix)
                random_query();
            send_item(CMD_LOAD, IDX_W'(order[k]), vals[order[k]], 1'b0, '0);
        end
    endtask

    initial
    begin
        int stall_mode;
        int stall_run;
        stall_mode = 0;
        stall_run = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_run == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_run = $urandom_range(1, 40);
            end
            stall_run--;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= 1'($urandom_range(0, 1));
                2: out_stall <= 1'b1;
                default: out_stall <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial
    begin
        logic [POS_W-1:0] want;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_positions.size() == 0)
                begin
                    $display("%0t ns: position expected none, got %0d", $time, position);
                    error_count++;
                end
                else
                begin
                    want = pending_positions.pop_front();
                    if (position !== want)
                    begin
                        $display("%0t ns: position expected %0d, got %0d",
                                 $time, want, position);
                        error_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        int phase;
        int n;
        error_count = 0;
        item_count = 0;
        burst_left = 0;
        loaded_prefix = 0;
        mirror_count = '0;
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        in_valid    <= 1'b0;
        cmd         <= CMD_LOAD;
        entry_index <= '0;
        value       <= '0;

        plan = '{
            '{ROW_ITEM, CMD_QUERY, 10'd0,    32'h0000_0000, 1'b1, 11'd0},
            '{ROW_ITEM, CMD_QUERY, 10'd1023, 32'h7FFF_FFFF, 1'b1, 11'd0},
            '{ROW_ITEM, CMD_QUERY, 10'd0,    32'h8000_0000, 1'b1, 11'd0},
            '{ROW_ITEM, CMD_LOAD,  10'd0,    32'h8000_0000, 1'b0, 11'd0},
            '{ROW_ITEM, CMD_LOAD,  10'd1,    32'hFFFF_FFFB, 1'b0, 11'd0},
            '{ROW_ITEM, CMD_LOAD,  10'd2,    32'h0000_0000, 1'b0, 11'd0},
            '{ROW_ITEM, CMD_LOAD,  10'd3,    32'h0000_0007, 1'b0, 11'd0},
            '{ROW_ITEM, CMD_LOAD,  10'd4,    32'h7FFF_FFFF, 1'b0, 11'd0},
            '{ROW_ITEM, CMD_LOAD,  10'd1023, 32'h5A5A_5A5A, 1'b0, 11'd0},
            '{ROW_CFG,  CMD_LOAD,  10'd0,    32'd5,         1'b0, 11'd0},
            '{ROW_ITEM, CMD_QUERY, 10'd0,    32'h8000_0000, 1'b1, 11'd1},
            '{ROW_ITEM, CMD_QUERY, 10'd0,    32'hFFFF_FFFA, 1'b1, 11'd1},
            '{ROW_ITEM, CMD_QUERY, 10'd0,    32'hFFFF_FFFB, 1'b1, 11'd2},
            '{ROW_ITEM, CMD_QUERY, 10'd0,    32'h0000_0000, 1'b1, 11'd3},
            '{ROW_ITEM, CMD_QUERY, 10'd0,    32'h0000_0006, 1'b1, 11'd3},
            '{ROW_ITEM, CMD_QUERY, 10'd0,    32'h0000_0007, 1'b1, 11'd4},
            '{ROW_ITEM, CMD_QUERY, 10'd1023, 32'h7FFF_FFFF, 1'b1, 11'd5},
            '{ROW_CFG,  CMD_LOAD,  10'd0,    32'd0,         1'b0, 11'd0},
            '{ROW_ITEM, CMD_QUERY, 10'd0,    32'h0000_0001, 1'b1, 11'd0},
            '{ROW_CFG,  CMD_LOAD,  10'd0,    32'd1,         1'b0, 11'd0},
            '{ROW_ITEM, CMD_QUERY, 10'd0,    32'h8000_0000, 1'b1, 11'd1},
            '{ROW_ITEM, CMD_LOAD,  10'd3,    32'hFFFF_FF9C, 1'b0, 11'd0},
            '{ROW_CFG,  CMD_LOAD,  10'd0,    32'd5,         1'b0, 11'd0},
            '{ROW_ITEM, CMD_QUERY, 10'd0,    32'h0000_0000, 1'b0, 11'd0},
            '{ROW_ITEM, CMD_QUERY, 10'd0,    32'hFFFF_FFCE, 1'b0, 11'd0}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
                configure_count(plan[i].data[CNT_W-1:0]);
            else
                send_item(plan[i].cmd, plan[i].slot, plan[i].data, plan[i].typed, plan[i].want);
        end

        // The whole table is loaded once so that full and oversized counts can be searched.
        phase = 0;
        while (item_count < ITEM_GOAL)
        begin
            if (phase == 4)
            begin
                fill_entries(TABLE_DEPTH, 1'b1, 1'b1, 1'b0, 5);
                configure_count(11'd1024);
                query_run(40);
                configure_count(11'd2047);
                query_run(25);
                configure_count(CNT_W'($urandom_range(513, 1023)));
                query_run(20);
            end
            else if (phase > 4 && $urandom_range(0, 9) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: configure_count(11'd1024);
                    1: configure_count(11'd2047);
                    2: configure_count(CNT_W'($urandom_range(1025, 2046)));
                    default: configure_count(CNT_W'($urandom_range(200, 1023)));
                endcase
                query_run(15);
            end
            else
            begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 48);
                configure_count(CNT_W'(n));
                fill_entries(n, $urandom_range(0, 1), $urandom_range(0, 5) != 0,
                             $urandom_range(0, 1), 0);
                query_run($urandom_range(8, 30));
            end
            phase++;
        end

        in_valid <= 1'b0;
        while (pending_positions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("[sorted_table_binary_search] OK");
        else
            $display("[sorted_table_binary_search] ERROR");
        $finish;
    end

endmodule

// ===== sorted_table_binary_search.f =====
+incdir+hdl
hdl/bsrch_pkg.sv
hdl/bsrch_table.sv
hdl/bsrch_ctrl.sv
hdl/sorted_table_binary_search.sv
hdl/bsrch_checker.sv
bench/sorted_table_binary_search_tb.sv
